// ===== rtl/lr_pkg.sv =====
// Shared definitions for the line rasterizer: field widths, defaults and
// the command and status groups between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package lr_pkg;

  localparam int FIELD_W = 6;
  localparam int COLOR_W = 8;
  localparam int COORD_BITS_DEF = 6;
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 40;

  typedef struct packed {
    logic load;
    logic setup;
    logic step;
  } lr_cmd_t;

  typedef struct packed {
    logic at_end;
  } lr_sts_t;

endpackage

// ===== rtl/lr_ctrl.sv =====
// Controller of the line rasterizer: sequences line intake, setup and
// pixel emission. Depends on lr_pkg.
`timescale 1ns / 1ps

module lr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  input  lr_pkg::lr_sts_t sts,
  output lr_pkg::lr_cmd_t cmd
);
  import lr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_RUN   = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (sts.at_end) begin
            state_next = ST_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/lr_dp.sv =====
// Datapath of the line rasterizer: endpoint and color registers, run
// normalization and the incremental exact-floor minor axis stepper.
// Depends on lr_pkg.
`timescale 1ns / 1ps

module lr_dp #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  lr_pkg::lr_cmd_t             cmd,
  output lr_pkg::lr_sts_t             sts,
  input  logic [lr_pkg::FIELD_W-1:0]  x_start,
  input  logic [lr_pkg::FIELD_W-1:0]  y_start,
  input  logic [lr_pkg::FIELD_W-1:0]  x_end,
  input  logic [lr_pkg::FIELD_W-1:0]  y_end,
  input  logic [lr_pkg::COLOR_W-1:0]  red,
  input  logic [lr_pkg::COLOR_W-1:0]  green,
  input  logic [lr_pkg::COLOR_W-1:0]  blue,
  output logic [lr_pkg::FIELD_W-1:0]  pix_x,
  output logic [lr_pkg::FIELD_W-1:0]  pix_y,
  output logic [lr_pkg::COLOR_W-1:0]  pix_red,
  output logic [lr_pkg::COLOR_W-1:0]  pix_grn,
  output logic [lr_pkg::COLOR_W-1:0]  pix_blue
);
  import lr_pkg::*;

  localparam int CB = COORD_BITS;

  logic [CB-1:0] x1, y1, x2, y2;
  logic [COLOR_W-1:0] red_q, green_q, blue_q;

  logic                steep;
  logic [CB-1:0]       pos;
  logic [CB-1:0]       end_pos;
  logic [CB-1:0]       minor;
  logic [CB-1:0]       den;
  logic signed [CB:0]  delta;
  logic signed [CB+1:0] rem;

  logic signed [CB:0] dx_s, dy_s;
  logic [CB:0]        adx_w, ady_w;
  logic               steep_w, swap_w;
  logic [CB-1:0]      maj_a, maj_b, min_a, min_b;
  logic signed [CB+1:0] rem_sum, den_s;

  always_comb begin
    dx_s = $signed({1'b0, x2}) - $signed({1'b0, x1});
    dy_s = $signed({1'b0, y2}) - $signed({1'b0, y1});
    adx_w = dx_s[CB] ? (CB+1)'(-dx_s) : dx_s;
    ady_w = dy_s[CB] ? (CB+1)'(-dy_s) : dy_s;
    steep_w = ady_w > adx_w;
    swap_w = steep_w ? (y1 > y2) : (x1 > x2);
    if (steep_w) begin
      maj_a = swap_w ? y2 : y1;
      maj_b = swap_w ? y1 : y2;
      min_a = swap_w ? x2 : x1;
      min_b = swap_w ? x1 : x2;
    end else begin
      maj_a = swap_w ? x2 : x1;
      maj_b = swap_w ? x1 : x2;
      min_a = swap_w ? y2 : y1;
      min_b = swap_w ? y1 : y2;
    end
  end

  assign den_s = $signed({2'b00, den});
  assign rem_sum = rem + $signed({delta[CB], delta});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1 <= x_start[CB-1:0];
      y1 <= y_start[CB-1:0];
      x2 <= x_end[CB-1:0];
      y2 <= y_end[CB-1:0];
      red_q <= red;
      green_q <= green;
      blue_q <= blue;
    end
    if (cmd.setup) begin
      steep <= steep_w;
      pos <= maj_a;
      end_pos <= maj_b;
      minor <= min_a;
      den <= maj_b - maj_a;
      delta <= $signed({1'b0, min_b}) - $signed({1'b0, min_a});
      rem <= '0;
    end else if (cmd.step) begin
      pos <= pos + 1'b1;
      if (!delta[CB] && (rem_sum >= den_s)) begin
        rem <= rem_sum - den_s;
        minor <= minor + 1'b1;
      end else if (delta[CB] && rem_sum[CB+1]) begin
        rem <= rem_sum + den_s;
        minor <= minor - 1'b1;
      end else begin
        rem <= rem_sum;
      end
    end
  end

  assign sts.at_end = (pos == end_pos);
  assign pix_x = FIELD_W'(steep ? minor : pos);
  assign pix_y = FIELD_W'(steep ? pos : minor);
  assign pix_red = red_q;
  assign pix_grn = green_q;
  assign pix_blue = blue_q;

endmodule

// ===== rtl/line_rasterizer.sv =====
// Line rasterizer top level: stream ports, controller and datapath.
// Depends on lr_pkg, lr_ctrl and lr_dp.
`timescale 1ns / 1ps

// One line is taken per item and its pixels leave one per cycle along the
// major axis while the output is not stalled, lowest coordinate first, with
// tlast on the final pixel. A line has 1 to 2^COORD_BITS pixels. The
// accepting cycle latches the line, the setup state normalizes it and loads
// the stepper, then pixels leave from the minor-axis remainder register,
// which adds the minor delta and makes at most one correction against the
// major length each step. The next line can be accepted in the cycle after
// the last pixel is delivered. An output stall holds the current pixel. A new
// line is taken only once the previous line's last pixel has been delivered.

module line_rasterizer #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // x_start[5:0], y_start[11:6], x_end[17:12], y_end[23:18],
  // red[31:24], green[39:32], blue[47:40]
  input  logic [lr_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // pix_x[5:0], pix_y[11:6], pix_red[19:12], pix_grn[27:20],
  // pix_blue[35:28], zero[39:36]
  output logic [lr_pkg::M_DATA_W-1:0]  m_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic                         m_tlast
);
  import lr_pkg::*;

  lr_cmd_t cmd;
  lr_sts_t sts;
  logic [FIELD_W-1:0] pix_x, pix_y;
  logic [COLOR_W-1:0] pix_red, pix_grn, pix_blue;

  lr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lr_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .sts       (sts),
    .x_start   (s_tdata[5:0]),
    .y_start   (s_tdata[11:6]),
    .x_end     (s_tdata[17:12]),
    .y_end     (s_tdata[23:18]),
    .red       (s_tdata[31:24]),
    .green     (s_tdata[39:32]),
    .blue      (s_tdata[47:40]),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .pix_red   (pix_red),
    .pix_grn   (pix_grn),
    .pix_blue  (pix_blue)
  );

  assign m_tdata = {4'b0000, pix_blue, pix_grn, pix_red, pix_y, pix_x};
  assign m_tlast = sts.at_end;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a pixel is pending");

  a_setup_gap: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !m_tvalid)
    else $error("pixel shown before line setup");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("line ended before its last pixel");

  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("not ready for a new line after the last pixel");

endmodule
